[rtl/ecef_to_geodetic_defines.svh]
// Assertion macros for the ECEF to geodetic converter.
// Included by the top level only; no other dependencies.
`ifndef ECEF_TO_GEODETIC_DEFINES_SVH
`define ECEF_TO_GEODETIC_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define ECG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ecef_to_geodetic: assertion failed");
// Check that a condition leads to another in the next cycle.
`define ECG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecef_to_geodetic: assertion failed");
`else
`define ECG_ASSERT(lbl, clk, rst_n, prop)
`define ECG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ecg_pkg.sv]
// Shared types, WGS84 constants and the CORDIC arctangent table.
// No dependencies; used by every file of the converter but ecg_dly and the defines header.
package ecg_pkg;

  localparam int unsigned POS_W   = 34;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned ALT_W   = 34;
  localparam int unsigned CORDIC_STEPS = 32;

  typedef logic signed [63:0] len_t;   // lengths, mm with 16 fraction bits
  typedef logic signed [33:0] ang_t;   // angles, 2^-32 turn
  typedef logic signed [31:0] trig_t;  // sines and cosines, Q30

  localparam ang_t  ANG_QUARTER   = 34'sd1073741824;
  localparam trig_t INVK_Q30      = 32'sd652032874;
  localparam logic signed [33:0] INVK_Q32   = 34'sd2608131496;
  localparam logic signed [33:0] AXIS_RATIO = 34'sd4280567084;
  localparam logic signed [33:0] E2_Q32     = 34'sd28752143;
  localparam len_t  EPB_Q4        = 64'sd685460984;
  localparam len_t  EA_Q4         = 64'sd683162763;
  localparam len_t  SEMI_MAJOR_MM = 64'sd6378137000;
  localparam len_t  ALT_MAX       = 64'sd8589934591;
  localparam len_t  ALT_MIN       = -64'sd8589934592;

  // arctangent of 2^-k in 2^-32 turn
  function automatic ang_t atan_lut(input logic [4:0] k);
    ang_t r;
    case (k)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/ecg_if.sv]
// Valid/ready channels for positions in and geodetic results out.
// Depends on ecg_pkg for field widths.
interface ecg_in_if;
  import ecg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ecg_out_if;
  import ecg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] latitude;
  logic signed [ANGLE_W-1:0] longitude;
  logic signed [ALT_W-1:0]   altitude_mm;
  logic                      altitude_saturated;
  modport source (output valid, latitude, longitude, altitude_mm, altitude_saturated,
                  input ready);
  modport sink   (input valid, latitude, longitude, altitude_mm, altitude_saturated,
                  output ready);
endinterface

[rtl/ecg_dly.sv]
// Enabled delay line that aligns operands between pipeline units.
// No package dependencies.
module ecg_dly #(
  parameter int unsigned W = 64,
  parameter int unsigned N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // shift one place per advancing cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

[rtl/ecg_mul.sv]
// Three-stage signed multiplier, rounding to nearest (ties away) after a shift.
// Operand a up to 63 magnitude bits, operand b up to 32; depends on ecg_pkg.
module ecg_mul #(
  parameter int unsigned SH = 30
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  ecg_pkg::len_t        a_i,
  input  logic signed [33:0]   b_i,
  output ecg_pkg::len_t        p_o
);
  import ecg_pkg::*;

  localparam logic [94:0] RND = 95'(1) << (SH - 1);

  logic [62:0] ma;
  logic [32:0] mb;
  logic [63:0] plo_q;
  logic [62:0] phi_q;
  logic        neg1_q, neg2_q;
  logic [94:0] sum_q;
  logic [62:0] mag;
  len_t        p_q;

  assign ma = a_i[63] ? 63'(-a_i) : a_i[62:0];
  assign mb = b_i[33] ? 33'(-b_i) : b_i[32:0];

  // stage 1: two 32-bit partial products of the magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      phi_q  <= 63'(ma[62:32]) * 63'(mb[31:0]);
      neg1_q <= a_i[63] ^ b_i[33];
    end
  end

  // stage 2: join the partial products and add the rounding half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= {phi_q, 32'b0} + 95'(plo_q) + RND;
      neg2_q <= neg1_q;
    end
  end

  // stage 3: scale down and restore the sign
  assign mag = 63'(sum_q >> SH);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg2_q ? -len_t'({1'b0, mag}) : len_t'({1'b0, mag});
    end
  end

  assign p_o = p_q;

endmodule

[rtl/ecg_vec.sv]
// Pipelined vectoring CORDIC: atan2(y, x) and gain-scaled magnitude.
// One pre-rotation stage plus one stage per iteration; depends on ecg_pkg.
module ecg_vec (
  input  logic          clk_i,
  input  logic          en_i,
  input  ecg_pkg::len_t x_i,
  input  ecg_pkg::len_t y_i,
  output ecg_pkg::ang_t ang_o,
  output ecg_pkg::len_t mag_o
);
  import ecg_pkg::*;

  len_t x_q [CORDIC_STEPS+1];
  len_t y_q [CORDIC_STEPS+1];
  ang_t a_q [CORDIC_STEPS+1];
  logic z_q [CORDIC_STEPS+1];

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0 && y_i >= 0) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        a_q[0] <= ANG_QUARTER;
      end else if (x_i < 0) begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        a_q[0] <= -ANG_QUARTER;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
    end
  end

  // drive y toward zero, one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    len_t dx, dy;
    assign dx = x_q[k] >>> k;
    assign dy = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[k+1] <= z_q[k];
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + dy;
          y_q[k+1] <= y_q[k] - dx;
          a_q[k+1] <= a_q[k] + atan_lut(5'(k));
        end else begin
          x_q[k+1] <= x_q[k] - dy;
          y_q[k+1] <= y_q[k] + dx;
          a_q[k+1] <= a_q[k] - atan_lut(5'(k));
        end
      end
    end
  end

  // a zero vector gives angle and magnitude zero
  assign ang_o = z_q[CORDIC_STEPS] ? '0 : a_q[CORDIC_STEPS];
  assign mag_o = z_q[CORDIC_STEPS] ? '0 : x_q[CORDIC_STEPS];

endmodule

[rtl/ecg_rot.sv]
// Pipelined rotation CORDIC: Q30 cosine and sine of an angle within a quarter turn.
// One stage per iteration; depends on ecg_pkg.
module ecg_rot (
  input  logic           clk_i,
  input  logic           en_i,
  input  ecg_pkg::ang_t  ang_i,
  output ecg_pkg::trig_t cos_o,
  output ecg_pkg::trig_t sin_o
);
  import ecg_pkg::*;

  trig_t cx_q [CORDIC_STEPS];
  trig_t cy_q [CORDIC_STEPS];
  ang_t  r_q  [CORDIC_STEPS];

  // rotate the prescaled unit vector toward the angle
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    trig_t cx, cy, dx, dy;
    ang_t  r;
    if (k == 0) begin : g_first
      assign cx = INVK_Q30;
      assign cy = '0;
      assign r  = ang_i;
    end else begin : g_next
      assign cx = cx_q[k-1];
      assign cy = cy_q[k-1];
      assign r  = r_q[k-1];
    end
    assign dx = cx >>> k;
    assign dy = cy >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r >= 0) begin
          cx_q[k] <= cx - dy;
          cy_q[k] <= cy + dx;
          r_q[k]  <= r - atan_lut(5'(k));
        end else begin
          cx_q[k] <= cx + dy;
          cy_q[k] <= cy - dx;
          r_q[k]  <= r + atan_lut(5'(k));
        end
      end
    end
  end

  assign cos_o = cx_q[CORDIC_STEPS-1];
  assign sin_o = cy_q[CORDIC_STEPS-1];

endmodule

[rtl/ecg_sqrt.sv]
// Pipelined integer square root, floor, one result bit per stage.
// Radicand below 2^62; depends on ecg_pkg for the stage count.
module ecg_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] v_i,
  output logic [31:0] root_o
);
  import ecg_pkg::*;

  logic [62:0] v_q   [CORDIC_STEPS];
  logic [62:0] res_q [CORDIC_STEPS];

  // test one power of four per stage, from the top down
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
    logic [62:0] v, res, trial;
    if (k == 0) begin : g_first
      assign v   = 63'(v_i);
      assign res = '0;
    end else begin : g_next
      assign v   = v_q[k-1];
      assign res = res_q[k-1];
    end
    assign trial = res + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v >= trial) begin
          v_q[k]   <= v - trial;
          res_q[k] <= (res >> 1) + BIT;
        end else begin
          v_q[k]   <= v;
          res_q[k] <= res >> 1;
        end
      end
    end
  end

  assign root_o = res_q[CORDIC_STEPS-1][31:0];

endmodule

[rtl/ecef_to_geodetic.sv]
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   pos_x, pos_y, pos_z (signed mm)
// out_o     out  valid/ready   latitude, longitude, altitude_mm, altitude_saturated
//
// The pipeline is built from three 33-stage vectoring CORDICs, two 32-stage
// rotation CORDICs, a 32-stage square root and chained 3-stage multipliers.
// One position enters per cycle unless out_o stalls; all stages advance together.
// Reset clears only the valid bits and the output register's valid.
// A stall at the output freezes every stage, so nothing is lost or repeated.
// Depends on ecg_pkg, ecg_if, ecg_dly, ecg_mul, ecg_vec, ecg_rot, ecg_sqrt.
module ecef_to_geodetic (
  input  logic      clk_i,
  input  logic      rst_ni,
  ecg_in_if.sink    in_i,
  ecg_out_if.source out_o
);
  import ecg_pkg::*;

  localparam int unsigned LAT = 223;

  `include "ecef_to_geodetic_defines.svh"

  logic en;
  logic [LAT-1:0] vld_q;
  logic out_vld_q;

  len_t vx, vy, vz;
  ang_t lon_ang, par, lat_raw;
  len_t kmag, rh, ax, rh_113, rh_180, vz_39, vz_113, vz_180;
  trig_t cp, sp, cp_3, sp_3, cl, sl;
  len_t cp2, sp2, c3, s3, nt, dt;
  len_t num_q, den_q;
  logic [1:0] spc_d;
  ang_t latang_q;
  len_t h1, h2, h1_222, h2_222, ss, es, h3;
  logic [30:0] w2_q;
  len_t w2;
  logic [31:0] wq;
  len_t hq_q, altv;
  logic [31:0] lon_223, lat_223;
  logic signed [ANGLE_W-1:0] lat_o_q, lon_o_q;
  logic signed [ALT_W-1:0] alt_o_q;
  logic sat_o_q;

  // advance the pipeline whenever the output register can take a result
  assign en = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign vx = {{14{in_i.pos_x[33]}}, in_i.pos_x, 16'h0};
  assign vy = {{14{in_i.pos_y[33]}}, in_i.pos_y, 16'h0};
  assign vz = {{14{in_i.pos_z[33]}}, in_i.pos_z, 16'h0};

  // valid bits ride alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // longitude and horizontal radius
  ecg_vec u_vec_lon (.clk_i, .en_i(en), .x_i(vx), .y_i(vy), .ang_o(lon_ang), .mag_o(kmag));
  ecg_mul #(.SH(32)) u_mul_rh (.clk_i, .en_i(en), .a_i(kmag), .b_i(INVK_Q32), .p_o(rh));
  ecg_dly #(.W(64), .N(39)) u_dly_vz39 (.clk_i, .en_i(en), .d_i(vz), .q_o(vz_39));

  // parametric angle and its sine and cosine
  ecg_mul #(.SH(32)) u_mul_ax (.clk_i, .en_i(en), .a_i(rh), .b_i(AXIS_RATIO), .p_o(ax));
  ecg_vec u_vec_par (.clk_i, .en_i(en), .x_i(ax), .y_i(vz_39), .ang_o(par), .mag_o());
  ecg_rot u_rot_par (.clk_i, .en_i(en), .ang_i(par), .cos_o(cp), .sin_o(sp));

  // cubes of sine and cosine
  ecg_mul #(.SH(30)) u_mul_sp2 (.clk_i, .en_i(en), .a_i(len_t'(sp)), .b_i(34'(sp)),
                                .p_o(sp2));
  ecg_mul #(.SH(30)) u_mul_cp2 (.clk_i, .en_i(en), .a_i(len_t'(cp)), .b_i(34'(cp)),
                                .p_o(cp2));
  ecg_dly #(.W(32), .N(3)) u_dly_sp (.clk_i, .en_i(en), .d_i(sp), .q_o(sp_3));
  ecg_dly #(.W(32), .N(3)) u_dly_cp (.clk_i, .en_i(en), .d_i(cp), .q_o(cp_3));
  ecg_mul #(.SH(30)) u_mul_s3 (.clk_i, .en_i(en), .a_i(sp2), .b_i(34'(sp_3)), .p_o(s3));
  ecg_mul #(.SH(30)) u_mul_c3 (.clk_i, .en_i(en), .a_i(cp2), .b_i(34'(cp_3)), .p_o(c3));
  ecg_mul #(.SH(18)) u_mul_nt (.clk_i, .en_i(en), .a_i(EPB_Q4), .b_i(34'(s3)), .p_o(nt));
  ecg_mul #(.SH(18)) u_mul_dt (.clk_i, .en_i(en), .a_i(EA_Q4), .b_i(34'(c3)), .p_o(dt));
  ecg_dly #(.W(64), .N(74)) u_dly_vz113 (.clk_i, .en_i(en), .d_i(vz_39), .q_o(vz_113));
  ecg_dly #(.W(64), .N(77)) u_dly_rh113 (.clk_i, .en_i(en), .d_i(rh), .q_o(rh_113));

  // form the Bowring numerator and denominator
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= vz_113 + nt;
      den_q <= rh_113 - dt;
    end
  end

  // latitude, forced to a pole when the denominator is not positive
  ecg_vec u_vec_lat (.clk_i, .en_i(en), .x_i(den_q), .y_i(num_q), .ang_o(lat_raw),
                     .mag_o());
  ecg_dly #(.W(2), .N(33)) u_dly_spc (.clk_i, .en_i(en),
                                      .d_i({den_q <= 0, num_q >= 0}), .q_o(spc_d));
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (spc_d[1]) begin
        latang_q <= spc_d[0] ? ANG_QUARTER : -ANG_QUARTER;
      end else if (lat_raw > ANG_QUARTER) begin
        latang_q <= ANG_QUARTER;
      end else if (lat_raw < -ANG_QUARTER) begin
        latang_q <= -ANG_QUARTER;
      end else begin
        latang_q <= lat_raw;
      end
    end
  end

  // sine and cosine of latitude and the projected terms
  ecg_rot u_rot_lat (.clk_i, .en_i(en), .ang_i(latang_q), .cos_o(cl), .sin_o(sl));
  ecg_dly #(.W(64), .N(67)) u_dly_vz180 (.clk_i, .en_i(en), .d_i(vz_113), .q_o(vz_180));
  ecg_dly #(.W(64), .N(67)) u_dly_rh180 (.clk_i, .en_i(en), .d_i(rh_113), .q_o(rh_180));
  ecg_mul #(.SH(30)) u_mul_h1 (.clk_i, .en_i(en), .a_i(rh_180), .b_i(34'(cl)), .p_o(h1));
  ecg_mul #(.SH(30)) u_mul_h2 (.clk_i, .en_i(en), .a_i(vz_180), .b_i(34'(sl)), .p_o(h2));
  ecg_dly #(.W(64), .N(39)) u_dly_h1 (.clk_i, .en_i(en), .d_i(h1), .q_o(h1_222));
  ecg_dly #(.W(64), .N(39)) u_dly_h2 (.clk_i, .en_i(en), .d_i(h2), .q_o(h2_222));

  // 1 - e2 sin^2, clipped at zero
  ecg_mul #(.SH(30)) u_mul_ss (.clk_i, .en_i(en), .a_i(len_t'(sl)), .b_i(34'(sl)), .p_o(ss));
  ecg_mul #(.SH(32)) u_mul_es (.clk_i, .en_i(en), .a_i(ss), .b_i(E2_Q32), .p_o(es));
  assign w2 = (64'sd1 <<< 30) - es;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q <= (w2 < 0) ? '0 : w2[30:0];
    end
  end

  // prime vertical term a * sqrt(1 - e2 sin^2)
  ecg_sqrt u_sqrt (.clk_i, .en_i(en), .v_i({1'b0, w2_q, 30'b0}), .root_o(wq));
  ecg_mul #(.SH(14)) u_mul_h3 (.clk_i, .en_i(en), .a_i(SEMI_MAJOR_MM),
                               .b_i({2'b00, wq}), .p_o(h3));

  always_ff @(posedge clk_i) begin
    if (en) begin
      hq_q <= h1_222 + h2_222 - h3;
    end
  end

  ecg_dly #(.W(32), .N(190)) u_dly_lon (.clk_i, .en_i(en), .d_i(lon_ang[31:0]),
                                        .q_o(lon_223));
  ecg_dly #(.W(32), .N(75)) u_dly_lat (.clk_i, .en_i(en), .d_i(latang_q[31:0]),
                                       .q_o(lat_223));

  // round altitude to mm, saturate, and hold the result until transfer
  assign altv = (hq_q + 64'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_o_q <= lat_223;
      lon_o_q <= lon_223;
      if (altv > ALT_MAX) begin
        alt_o_q <= ALT_MAX[ALT_W-1:0];
        sat_o_q <= 1'b1;
      end else if (altv < ALT_MIN) begin
        alt_o_q <= ALT_MIN[ALT_W-1:0];
        sat_o_q <= 1'b1;
      end else begin
        alt_o_q <= altv[ALT_W-1:0];
        sat_o_q <= 1'b0;
      end
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.latitude           = lat_o_q;
  assign out_o.longitude          = lon_o_q;
  assign out_o.altitude_mm        = alt_o_q;
  assign out_o.altitude_saturated = sat_o_q;

  // checks
  `ECG_ASSERT(a_sat_at_limit, clk_i, rst_ni,
    out_vld_q && sat_o_q |-> alt_o_q == ALT_MAX[ALT_W-1:0] || alt_o_q == ALT_MIN[ALT_W-1:0])
  `ECG_ASSERT(a_lat_range, clk_i, rst_ni,
    out_vld_q |-> lat_o_q <= 32'sd1073741824 && lat_o_q >= -32'sd1073741824)
  `ECG_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, !en, $stable(vld_q) && $stable(hq_q))

endmodule

[dv/ecef_to_geodetic_tb.sv]
// Self-checking testbench for the ECEF to WGS84 geodetic converter.
// Drives positions through ecg_in_if and checks every result against a local predictor.
// Depends on ecg_pkg, ecg_if and the ecef_to_geodetic top level.
`timescale 1ns / 1ps

module ecef_to_geodetic_tb;
  import ecg_pkg::*;

  localparam int          PIPE_DEPTH  = 224;
  localparam int          CYCLE_LIMIT = 400000;
  localparam longint      QUARTER     = 64'sd1073741824;
  localparam longint      POLAR_MM    = 64'sd6356752314;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] lat;
    logic signed [ANGLE_W-1:0] lon;
    logic signed [ALT_W-1:0]   alt;
    logic                      sat;
  } geo_t;

  logic clk;
  logic rst_n;
  int   cycle_cnt;
  int   err_cnt;
  int   accepted_cnt;

  pos_t positions_pending[$];
  geo_t geo_expected[$];

  ecg_in_if  in_if ();
  ecg_out_if out_if ();

  ecef_to_geodetic dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor
  // round(u*v / 2^sh), ties away from zero
  function automatic longint mul_round(longint u, longint v, int sh);
    logic            neg;
    logic [127:0]    prod;
    longint unsigned mu;
    longint unsigned mv;
    longint unsigned q;
    neg  = (u < 0) != (v < 0);
    mu   = (u < 0) ? -u : u;
    mv   = (v < 0) ? -v : v;
    prod = {64'd0, mu} * {64'd0, mv};
    prod = prod + (128'd1 << (sh - 1));
    q    = 64'(prod >> sh);
    q[63] = 1'b0;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint atan_step(int k);
    return longint'(atan_lut(k[4:0]));
  endfunction

  // vectoring CORDIC: angle of (vx, vy), gain-scaled magnitude
  function automatic longint cordic_atan2(longint vx, longint vy, output longint mag);
    longint acc;
    longint t;
    longint dx;
    longint dy;
    acc = 0;
    if (vx == 0 && vy == 0) begin
      mag = 0;
      return 0;
    end
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; acc = QUARTER;
      end else begin
        vx = -vy; vy = t; acc = -QUARTER;
      end
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = vx >>> k;
      dy = vy >>> k;
      if (vy > 0) begin
        vx += dy; vy -= dx; acc += atan_step(k);
      end else begin
        vx -= dy; vy += dx; acc -= atan_step(k);
      end
    end
    mag = vx;
    return acc;
  endfunction

  // rotation CORDIC: Q30 cosine and sine
  function automatic void cordic_sincos(longint ang, output longint co, output longint si);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    cx = longint'(INVK_Q30);
    cy = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = cx >>> k;
      dy = cy >>> k;
      if (ang >= 0) begin
        cx -= dy; cy += dx; ang -= atan_step(k);
      end else begin
        cx += dy; cy -= dx; ang += atan_step(k);
      end
    end
    co = cx;
    si = cy;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic geo_t predict_geodetic(pos_t p);
    geo_t   g;
    longint vx, vy, vz, kmag, dummy, rh, par, cp, sp, c3, s3, num, den;
    longint lat, lon, cl, sl, w2, wq, hq, alt;
    vx  = longint'(p.x) * 65536;
    vy  = longint'(p.y) * 65536;
    vz  = longint'(p.z) * 65536;
    lon = cordic_atan2(vx, vy, kmag);
    rh  = mul_round(kmag, longint'(INVK_Q32), 32);
    par = cordic_atan2(mul_round(rh, longint'(AXIS_RATIO), 32), vz, dummy);
    cordic_sincos(par, cp, sp);
    s3  = mul_round(mul_round(sp, sp, 30), sp, 30);
    c3  = mul_round(mul_round(cp, cp, 30), cp, 30);
    num = vz + mul_round(EPB_Q4, s3, 18);
    den = rh - mul_round(EA_Q4, c3, 18);
    // degenerate denominator near the axis: snap to a pole
    if (den <= 0) begin
      lat = (num >= 0) ? QUARTER : -QUARTER;
    end else begin
      lat = cordic_atan2(den, num, dummy);
      if (lat > QUARTER) lat = QUARTER;
      if (lat < -QUARTER) lat = -QUARTER;
    end
    cordic_sincos(lat, cl, sl);
    w2 = (64'sd1 <<< 30) - mul_round(E2_Q32, mul_round(sl, sl, 30), 32);
    if (w2 < 0) w2 = 0;
    wq  = longint'(floor_sqrt(longint'(w2) << 30));
    hq  = mul_round(rh, cl, 30) + mul_round(vz, sl, 30) - mul_round(SEMI_MAJOR_MM, wq, 14);
    alt = (hq + (64'sd1 <<< 15)) >>> 16;
    g.sat = 1'b0;
    if (alt > ALT_MAX) begin
      alt = ALT_MAX; g.sat = 1'b1;
    end
    if (alt < ALT_MIN) begin
      alt = ALT_MIN; g.sat = 1'b1;
    end
    g.lat = lat[31:0];
    g.lon = lon[31:0];
    g.alt = alt[33:0];
    return g;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [POS_W-1:0] rand_full();
    return {2'($urandom_range(3, 0)), 32'($urandom)};
  endfunction

  function automatic logic signed [POS_W-1:0] rand_span(longint span);
    return POS_W'(longint'($urandom_range(32'(2 * span), 0)) - span);
  endfunction

  function automatic pos_t make_pos(longint x, longint y, longint z);
    pos_t p;
    p.x = x[33:0];
    p.y = y[33:0];
    p.z = z[33:0];
    return p;
  endfunction

  function automatic pos_t rand_position();
    pos_t p;
    case ($urandom_range(9, 0))
      0, 1: begin
        // full-range noise, every bit toggles
        p.x = rand_full(); p.y = rand_full(); p.z = rand_full();
      end
      2: begin
        // close to the polar axis
        p.x = rand_span(20000); p.y = rand_span(20000);
        p.z = $urandom_range(1, 0) ? POS_W'(rand_span(2000000000) + POLAR_MM)
                                   : POS_W'(rand_span(2000000000) - POLAR_MM);
      end
      3: begin
        // near the centre
        p.x = rand_span(1000000); p.y = rand_span(1000000); p.z = rand_span(1000000);
      end
      default: begin
        // plausible near-Earth positions
        p.x = rand_span(2000000000) * 3;
        p.y = rand_span(2000000000) * 3;
        p.z = rand_span(2000000000) * 3;
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------- driver
  int burst_left;
  int gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pos_x <= '0;
      in_if.pos_y <= '0;
      in_if.pos_z <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (burst_left == 0) begin
        // hold idle through the gap, then open a new burst
        in_if.valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          burst_left <= $urandom_range(60, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
        end
      end else if (positions_pending.size() > 0) begin
        pos_t p;
        p = positions_pending.pop_front();
        in_if.pos_x <= p.x;
        in_if.pos_y <= p.y;
        in_if.pos_z <= p.z;
        in_if.valid <= 1'b1;
        burst_left  <= burst_left - 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_left;
  int mode_left;
  int stall_mode;
  logic long_hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready   <= 1'b0;
      hold_left      <= 0;
      mode_left      <= 0;
      stall_mode     <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && accepted_cnt >= 150) begin
      // one long hold-off so the pipeline fills and back-pressures the input
      out_if.ready   <= 1'b0;
      hold_left      <= 600;
      long_hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2, 0);
        mode_left  <= $urandom_range(300, 50);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(3, 0) != 0);
        default: out_if.ready <= ($urandom_range(1, 0) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst_n) begin
      // predict on each input transfer
      if (in_if.valid && in_if.ready) begin
        geo_expected.push_back(predict_geodetic(make_pos(in_if.pos_x, in_if.pos_y,
                                                         in_if.pos_z)));
        accepted_cnt <= accepted_cnt + 1;
      end
      // compare each output transfer with the oldest prediction
      if (out_if.valid && out_if.ready) begin
        if (geo_expected.size() == 0) begin
          $display("%0t: unexpected result lat=%0d lon=%0d alt=%0d sat=%0b", $realtime,
                   out_if.latitude, out_if.longitude, out_if.altitude_mm,
                   out_if.altitude_saturated);
          err_cnt++;
        end else begin
          geo_t g;
          g = geo_expected.pop_front();
          if (out_if.latitude !== g.lat) begin
            $display("%0t: latitude expected %0d actual %0d", $realtime, g.lat,
                     out_if.latitude);
            err_cnt++;
          end
          if (out_if.longitude !== g.lon) begin
            $display("%0t: longitude expected %0d actual %0d", $realtime, g.lon,
                     out_if.longitude);
            err_cnt++;
          end
          if (out_if.altitude_mm !== g.alt) begin
            $display("%0t: altitude_mm expected %0d actual %0d", $realtime, g.alt,
                     out_if.altitude_mm);
            err_cnt++;
          end
          if (out_if.altitude_saturated !== g.sat) begin
            $display("%0t: altitude_saturated expected %0b actual %0b", $realtime, g.sat,
                     out_if.altitude_saturated);
            err_cnt++;
          end
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (positions_pending.size() > 0 || in_if.valid || geo_expected.size() > 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    cycle_cnt    = 0;
    err_cnt      = 0;
    accepted_cnt = 0;

    // directed: zero, extremes, poles, longitude at pi, centre region
    positions_pending.push_back(make_pos(0, 0, 0));
    positions_pending.push_back(make_pos(64'sd8589934591, 64'sd8589934591,
                                         64'sd8589934591));
    positions_pending.push_back(make_pos(-64'sd8589934592, -64'sd8589934592,
                                         -64'sd8589934592));
    positions_pending.push_back(make_pos(64'sd8589934591, -64'sd8589934592, 0));
    positions_pending.push_back(make_pos(-64'sd8589934592, 0, 64'sd8589934591));
    positions_pending.push_back(make_pos(0, 0, POLAR_MM));
    positions_pending.push_back(make_pos(0, 0, -POLAR_MM));
    positions_pending.push_back(make_pos(0, 0, 64'sd8589934591));
    positions_pending.push_back(make_pos(0, 0, -64'sd8589934592));
    positions_pending.push_back(make_pos(-64'sd6378137000, 0, 0));
    positions_pending.push_back(make_pos(-64'sd8589934592, 0, 0));
    positions_pending.push_back(make_pos(64'sd6378137000, 0, 0));
    positions_pending.push_back(make_pos(0, 64'sd6378137000, 0));
    positions_pending.push_back(make_pos(0, -64'sd6378137000, 0));
    positions_pending.push_back(make_pos(1, 0, 0));
    positions_pending.push_back(make_pos(0, 0, 1));
    positions_pending.push_back(make_pos(0, 0, -1));
    positions_pending.push_back(make_pos(-1, -1, -1));
    positions_pending.push_back(make_pos(1000, 0, 1000000));
    positions_pending.push_back(make_pos(64'sd4510000000, 64'sd4510000000, 0));
    positions_pending.push_back(make_pos(64'sd3000000000, -64'sd2000000000,
                                         64'sd5000000000));
    positions_pending.push_back(make_pos(0, 0, 64'sd8000000000));
    positions_pending.push_back(make_pos(-5, 3, -64'sd8589934592));

    for (int i = 0; i < 450; i++) positions_pending.push_back(rand_position());

    // pause the sender until every result is back
    @(posedge rst_n);
    wait_drained();

    for (int i = 0; i < 450; i++) positions_pending.push_back(rand_position());
    wait_drained();
    repeat (PIPE_DEPTH + 50) @(posedge clk);

    if (err_cnt == 0 && geo_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
